FILE: sv/mrq_pkg.sv
`default_nettype none

package mrq_pkg;

    // Fixed widths of the item fields
    localparam int unsigned OP_W      = 2;
    localparam int unsigned MSG_PORT_W = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned LEVEL_W   = 5;
    localparam int unsigned CAP_W     = 5;

    // Defaults for the top-level parameters
    localparam int unsigned DEPTH_DEFAULT     = 16;
    localparam int unsigned MSG_WIDTH_DEFAULT = 32;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_POST  = 2'd0,
        OP_TAKE  = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

FILE: sv/mrq_if.sv
`default_nettype none

interface mrq_in_if
    import mrq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [MSG_PORT_W-1:0] msg_in;
    logic                  to_front;
    logic                  waiter_present;

    modport source (output valid, op, msg_in, to_front, waiter_present, input ready);
    modport sink   (input valid, op, msg_in, to_front, waiter_present, output ready);
endinterface

interface mrq_out_if
    import mrq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [MSG_PORT_W-1:0] msg_out;
    logic                  handed_over;
    logic [LEVEL_W-1:0]    fill_level;

    modport source (output valid, status, msg_out, handed_over, fill_level, input ready);
    modport sink   (input valid, status, msg_out, handed_over, fill_level, output ready);
endinterface

`default_nettype wire

FILE: sv/mrq_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module mrq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/mailbox_ring_queue.sv
`default_nettype none

// Mailbox ring queue. Each input item is one operation: post (op 0), take
// (op 1) or flush (op 2); each gives exactly one result item carrying status,
// the message taken or handed over, a handed-over flag and the fill level
// after the operation. Messages live in a synchronous RAM of DEPTH words;
// head, tail and fill count live in flops. A post, a handover, a flush or a
// refused/empty operation goes straight to the output register, so such items
// can be taken every cycle while results are accepted. A take that finds a
// message builds its result from registered RAM data in the read state. The
// capacity register (1 to DEPTH, 0 acts as 1) sets the wrap point of both
// indices; write it only while the block is idle. Slot contents are not
// cleared at reset, so there is no clearing pass after reset. A new item is
// let in on the same edge as the previous result leaves the output register;
// while a result waits unaccepted, the input is held off.
module mailbox_ring_queue
    import mrq_pkg::*;
#(
    parameter int unsigned DEPTH     = DEPTH_DEFAULT,
    parameter int unsigned MSG_WIDTH = MSG_WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    mrq_in_if.sink                in_ch,
    mrq_out_if.source             out_ch,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    localparam int unsigned IW = $clog2(DEPTH);
    // wide enough for index + 1 and for the capacity register
    localparam int unsigned CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

    // Control and index state
    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [LEVEL_W-1:0]  held_reg, held_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [MSG_PORT_W-1:0] out_msg_reg, out_msg_next;
    logic                  out_handed_reg, out_handed_next;
    logic [LEVEL_W-1:0]    out_fill_reg, out_fill_next;

    // RAM port
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [MSG_WIDTH-1:0] ram_rdata;

    logic                 in_acc;
    logic                 out_free;
    logic [CW-1:0]        eff_cap;
    logic [MSG_WIDTH-1:0] msg_cut;

    // Index step forward: wraps to 0 at or beyond capacity
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        begin
            n = CW'(idx) + CW'(1);
            idx_inc = (n >= cap) ? '0 : IW'(n);
        end
    endfunction

    // Index step back: from 0 to capacity - 1
    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
        begin
            idx_dec = (idx == '0) ? IW'(cap - CW'(1)) : idx - IW'(1);
        end
    endfunction

    // Effective capacity: clamped to 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign msg_cut  = MSG_WIDTH'(in_ch.msg_in);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_msg_next    = out_msg_reg;
        out_handed_next = out_handed_reg;
        out_fill_next   = out_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_re          = 1'b0;

        if (state_reg == ST_READ)
        begin
            // RAM data for the take is here; held/head were updated at accept
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_msg_next    = MSG_PORT_W'(ram_rdata);
            out_handed_next = 1'b0;
            out_fill_next   = held_reg;
            state_next      = ST_IDLE;
        end
        else if (in_acc)
        begin
            out_status_next = STATUS_OK;
            out_msg_next    = '0;
            out_handed_next = 1'b0;
            out_valid_next  = 1'b1;
            case (op_t'(in_ch.op))
                OP_POST:
                begin
                    if (in_ch.waiter_present)
                    begin
                        // direct handover, ring untouched
                        out_msg_next    = MSG_PORT_W'(msg_cut);
                        out_handed_next = 1'b1;
                    end
                    else if (CW'(held_reg) >= eff_cap)
                    begin
                        out_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (in_ch.to_front)
                        begin
                            head_next = idx_dec(head_reg, eff_cap);
                            ram_waddr = head_next;
                        end
                        else
                        begin
                            ram_waddr = tail_reg;
                            tail_next = idx_inc(tail_reg, eff_cap);
                        end
                        held_next = held_reg + LEVEL_W'(1);
                    end
                end
                OP_TAKE:
                begin
                    if (held_reg != '0)
                    begin
                        ram_re         = 1'b1;
                        held_next      = held_reg - LEVEL_W'(1);
                        head_next      = idx_inc(head_reg, eff_cap);
                        out_valid_next = 1'b0;
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        out_status_next = STATUS_EMPTY;
                    end
                end
                OP_FLUSH:
                begin
                    if (!in_ch.waiter_present)
                    begin
                        held_next = '0;
                        head_next = '0;
                        tail_next = '0;
                    end
                end
                default:
                begin
                    // unused code: no change, plain ok result
                end
            endcase
            out_fill_next = held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            held_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_msg_reg    <= out_msg_next;
        out_handed_reg <= out_handed_next;
        out_fill_reg   <= out_fill_next;
    end

    mrq_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (msg_cut),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.msg_out     = out_msg_reg;
    assign out_ch.handed_over = out_handed_reg;
    assign out_ch.fill_level  = out_fill_reg;

    // Fill count never passes the RAM size
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= 32'(DEPTH))
        else $error("fill count above ring depth");

    // The read wait state only starts with the output register free
    a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("take result would overwrite a pending item");

    // After the read wait state a take returns to idle and delivers its result
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("take result not delivered after RAM read");

    // No item is taken while the take result is being built
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !in_ch.ready)
        else $error("input accepted during RAM read wait");

endmodule

`default_nettype wire

FILE: tb/tb_mailbox_ring_queue.sv
`timescale 1ns / 1ps

module tb_mailbox_ring_queue;
    import mrq_pkg::*;

    // Run limit. The slowest correct item meets the largest sender gap, the
    // largest receiver stall and the read wait of a take. About 1925 items
    // and ten capacity writes make up the run.
    localparam int unsigned CYCLE_LIMIT = 300_000;
    localparam int unsigned PHASE_ITEMS = 190;

    // One result item as the block should return it
    typedef struct {
        status_t          status;
        logic [31:0]      msg;
        logic             handed;
        logic [LEVEL_W-1:0] level;
    } mrq_result_t;

    // Scoreboard: its own copy of the ring, the counters and the capacity
    // register, and the results still owed by the block, oldest first.
    class mailbox_scoreboard;
        logic [31:0]      slots [DEPTH_DEFAULT];
        int unsigned      held;
        int unsigned      head;
        int unsigned      tail;
        logic [CAP_W-1:0] capacity;
        mrq_result_t      owed_results [$];
        int unsigned      errors;

        function new();
            held     = 0;
            head     = 0;
            tail     = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        // Step an index forward; anything at or past the wrap point goes to 0
        function int unsigned step_on(int unsigned idx, int unsigned cap);
            return (idx + 1 >= cap) ? 0 : idx + 1;
        endfunction

        // Called for every accepted input item: updates the ring and queues
        // the result it should give
        function void note_op(op_t op, logic [31:0] msg, logic front, logic waiter);
            mrq_result_t r;
            int unsigned cap;
            cap = (capacity == 0) ? 1 :
                  (capacity > DEPTH_DEFAULT) ? DEPTH_DEFAULT : capacity;
            r.status = STATUS_OK;
            r.msg    = '0;
            r.handed = 1'b0;
            case (op)
                OP_POST:
                begin
                    if (waiter)
                    begin
                        // handover beats the full check, ring untouched
                        r.msg    = msg;
                        r.handed = 1'b1;
                    end
                    else if (held >= cap)
                        r.status = STATUS_FULL;
                    else
                    begin
                        if (front)
                        begin
                            head        = (head == 0) ? cap - 1 : head - 1;
                            slots[head] = msg;
                        end
                        else
                        begin
                            slots[tail] = msg;
                            tail        = step_on(tail, cap);
                        end
                        held++;
                    end
                end
                OP_TAKE:
                begin
                    // waiter flag plays no part in a take
                    if (held > 0)
                    begin
                        held--;
                        r.msg = slots[head];
                        head  = step_on(head, cap);
                    end
                    else
                        r.status = STATUS_EMPTY;
                end
                OP_FLUSH:
                begin
                    if (!waiter)
                    begin
                        held = 0;
                        head = 0;
                        tail = 0;
                    end
                end
                default:
                begin
                end
            endcase
            r.level = held[LEVEL_W-1:0];
            owed_results.push_back(r);
        endfunction

        // Called for every accepted result item
        function void check_result(logic [STATUS_W-1:0] status, logic [31:0] msg,
                                   logic handed, logic [LEVEL_W-1:0] level);
            mrq_result_t r;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result item with none owed: status %0d msg %h level %0d",
                         $time, status, msg, level);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (status !== r.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, r.status, status);
                errors++;
            end
            if (msg !== r.msg)
            begin
                $display("%0t: msg_out expected %h, got %h", $time, r.msg, msg);
                errors++;
            end
            if (handed !== r.handed)
            begin
                $display("%0t: handed_over expected %0d, got %0d", $time, r.handed, handed);
                errors++;
            end
            if (level !== r.level)
            begin
                $display("%0t: fill_level expected %0d, got %0d", $time, r.level, level);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    mrq_in_if  in_ch ();
    mrq_out_if out_ch ();

    mailbox_scoreboard sb;

    // Set by the stimulus for stretches where neither side idles
    bit          steady;
    int unsigned cycle_count;

    mailbox_ring_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item. Fields change on the falling edge; acceptance is seen on
    // the rising edge. Valid is left high afterwards so that a following item
    // with no gap goes out back to back.
    task automatic send_op(op_t op, logic [31:0] msg, logic front, logic waiter);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.op             <= op;
        in_ch.msg_in         <= msg;
        in_ch.to_front       <= front;
        in_ch.waiter_present <= waiter;
        in_ch.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_op(op, msg, front, waiter);
    endtask

    // Stop sending and hold off until every owed result has come back
    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Capacity may only change with the block idle; every item gives a
    // result, so idle means nothing owed
    task automatic set_capacity(logic [CAP_W-1:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.capacity = value;
    endtask

    // One phase of random items. The mix swings between filling and draining
    // runs so that full and empty are both reached at every capacity; the
    // odd flush and waiter keep those paths busy too.
    task automatic run_phase(int unsigned n_items);
        op_t         op;
        logic [31:0] msg;
        logic        front;
        logic        waiter;
        bit          filling;
        int unsigned pick;
        filling = 1'b1;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (i % 24 == 0)
            begin
                filling = $urandom_range(0, 1);
                steady  = ($urandom_range(0, 3) == 0);
            end
            // the occasional full drain mid-phase
            if ($urandom_range(0, 149) == 0)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_FLUSH;
            else if (filling ? (pick < 72) : (pick < 28))
                op = OP_POST;
            else
                op = OP_TAKE;
            case ($urandom_range(0, 9))
                0:       msg = '0;
                1:       msg = '1;
                default: msg = $urandom;
            endcase
            front  = $urandom_range(0, 1);
            waiter = ($urandom_range(0, 4) == 0);
            send_op(op, msg, front, waiter);
        end
    endtask

    // Result side: draw a stall per item, then take whatever arrives
    initial
    begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            sb.check_result(out_ch.status, out_ch.msg_out, out_ch.handed_over,
                            out_ch.fill_level);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [CAP_W-1:0] caps [10];
        sb                   = new();
        steady               = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_ch.valid          = 1'b0;
        in_ch.op             = OP_POST;
        in_ch.msg_in         = '0;
        in_ch.to_front       = 1'b0;
        in_ch.waiter_present = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity of 16
        send_op(OP_TAKE, 32'h0, 1'b0, 1'b0);            // take on an empty ring
        send_op(OP_FLUSH, 32'h0, 1'b0, 1'b0);           // flush with nothing held
        send_op(OP_POST, 32'hFFFF_FFFF, 1'b0, 1'b1);    // handover, ring untouched
        // Fill the ring from both ends; this writes all 16 slots, so no take
        // later on can land on a slot that was never written
        for (int unsigned i = 0; i < 16; i++)
            send_op(OP_POST, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                    i[0], 1'b0);
        send_op(OP_POST, 32'h1234_5678, 1'b1, 1'b0);    // refused, ring full
        send_op(OP_POST, 32'h8765_4321, 1'b0, 1'b1);    // handover on a full ring
        send_op(OP_FLUSH, 32'h0, 1'b0, 1'b1);           // flush ignored with waiter
        send_op(OP_TAKE, 32'h0, 1'b0, 1'b1);            // waiter has no say in a take
        send_op(OP_TAKE, 32'h0, 1'b1, 1'b0);
        send_op(OP_FLUSH, 32'h0, 1'b0, 1'b0);

        // Random phases across capacities, the extremes among them. The ring
        // is not flushed between phases, so lowering the capacity leaves the
        // fill count and indices past the new wrap point.
        caps[0] = 5'd1;
        caps[1] = 5'd16;
        caps[2] = 5'd0;     // acts as 1
        caps[3] = 5'd5;
        caps[4] = 5'd31;    // acts as 16
        caps[5] = 5'd2;
        caps[6] = 5'd17;
        caps[7] = 5'd16;
        caps[8] = 5'd3;
        caps[9] = $urandom_range(1, 16);
        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            run_phase(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: mailbox_ring_queue.f
sv/mrq_pkg.sv
sv/mrq_if.sv
sv/mrq_ram.sv
sv/mailbox_ring_queue.sv
tb/tb_mailbox_ring_queue.sv
